### rtl/mono_framebuffer_palette_macros.svh
// ----------------------------------------------------------------------------
// mono_framebuffer_palette_macros.svh
// Assertion macros for the mono frame buffer; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_PALETTE_MACROS_SVH
`define MONO_FRAMEBUFFER_PALETTE_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define MFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// cons must hold in the cycle after ante
`define MFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFP_ASSERT(lbl, prop, msg)
`define MFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants of the mono frame buffer.
// ----------------------------------------------------------------------------
package mfp_pkg;

  localparam int unsigned MaxPixels  = 65536;
  localparam int unsigned StoreWords = MaxPixels / 8;
  localparam int unsigned WordAddrW  = $clog2(StoreWords);
  localparam int unsigned PixCntW    = $clog2(MaxPixels + 1);
  localparam int unsigned WordCntW   = $clog2(StoreWords + 1);

  localparam int unsigned DimW    = 13;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned PosW    = 16;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ColourW = 16;
  localparam int unsigned ProdW   = 2 * DimW;

  localparam int unsigned InDataW  = 2 * CoordW + PosW + 3 * ChanW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_RD_XY  = 2'd1,
    REQ_RD_IDX = 2'd2,
    REQ_FILL   = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ON     = 2'd2,
    CFG_OFF    = 2'd3
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;   // input side open
    logic capture;    // latch input beat
    logic calc;       // form pixel index
    logic mem_rd;     // read word at pixel index
    logic set_wr;     // write modified word back
    logic sweep_wr;   // sweep write at counter
    logic sweep_clr;  // sweep writes zero (post-reset clear)
    logic load_out;   // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_e req;
    logic in_range;
    logic clear_last;
    logic fill_last;
    logic frame_empty;
    logic out_valid;
  } sts_t;

endpackage

### rtl/mfp_ctrl.sv
// ----------------------------------------------------------------------------
// mfp_ctrl
// Sequencer: post-reset clear, request decode, fill sweep, result hand-off.
// ----------------------------------------------------------------------------
module mfp_ctrl
  import mfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_FILL,
    ST_READ,
    ST_DATA,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep_wr  = 1'b1;
        cmd_o.sweep_clr = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.capture  = in_valid_i;
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = (sts_i.req == REQ_FILL) ? ST_FILL : ST_READ;
      end
      ST_FILL: begin
        if (sts_i.frame_empty) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.sweep_wr = 1'b1;
          if (sts_i.fill_last) state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_DATA;
      end
      ST_DATA: begin
        if (sts_i.req == REQ_SET) begin
          cmd_o.set_wr = sts_i.in_range;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!sts_i.out_valid || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/mfp_dp.sv
// ----------------------------------------------------------------------------
// mfp_dp
// Datapath: config registers, frame extent, index math, frame store, result.
// ----------------------------------------------------------------------------
module mfp_dp
  import mfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic [1:0]           in_user_i,
  input  logic [InDataW-1:0]   in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [ColourW-1:0]   out_data_o,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  // configuration
  logic [DimW-1:0]    width_q, height_q;
  logic [ColourW-1:0] on_col_q, off_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DimW'(128);
      height_q  <= DimW'(64);
      on_col_q  <= '1;
      off_col_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q   <= cfg_wdata_i[DimW-1:0];
        CFG_HEIGHT: height_q  <= cfg_wdata_i[DimW-1:0];
        CFG_ON:     on_col_q  <= cfg_wdata_i[ColourW-1:0];
        CFG_OFF:    off_col_q <= cfg_wdata_i[ColourW-1:0];
        default:    ;
      endcase
    end
  end

  // frame extent: product, then clamp
  logic [ProdW-1:0]    area_q;
  logic [PixCntW-1:0]  frame_pix_q;
  logic [WordCntW:0]   words_sum;
  logic [WordCntW-1:0] words;
  logic [WordCntW-1:0] words_m1;

  always_ff @(posedge clk_i) begin
    area_q      <= ProdW'(width_q) * ProdW'(height_q);
    frame_pix_q <= (area_q > ProdW'(MaxPixels)) ? PixCntW'(MaxPixels)
                                                : area_q[PixCntW-1:0];
  end

  assign words_sum = (WordCntW+1)'((frame_pix_q + PixCntW'(7)) >> 3);
  assign words     = words_sum[WordCntW-1:0];
  assign words_m1  = words - WordCntW'(1);

  // captured request
  req_e              req_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [PosW-1:0]   lin_q;
  logic              on_q;
  logic [PosW-1:0]   pos_q;
  logic [ProdW-1:0]  xy_pos;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_e'(in_user_i);
      x_q   <= in_data_i[CoordW-1:0];
      y_q   <= in_data_i[2*CoordW-1:CoordW];
      lin_q <= in_data_i[2*CoordW+PosW-1:2*CoordW];
      // sum of channels is nonzero iff any channel is
      on_q  <= |in_data_i[InDataW-1:2*CoordW+PosW];
    end
  end

  assign xy_pos = ProdW'(x_q) + ProdW'(y_q) * ProdW'(width_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      pos_q <= (req_q == REQ_RD_IDX) ? lin_q : xy_pos[PosW-1:0];
    end
  end

  logic in_range;
  assign in_range = PixCntW'(pos_q) < frame_pix_q;

  // sweep counter (clear and fill)
  logic [WordAddrW-1:0] cnt_q;
  logic                 clear_last, fill_last, sweep_last;

  assign clear_last = &cnt_q;
  assign fill_last  = cnt_q == words_m1[WordAddrW-1:0];
  assign sweep_last = cmd_i.sweep_clr ? clear_last : fill_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep_wr) begin
      cnt_q <= sweep_last ? '0 : cnt_q + WordAddrW'(1);
    end
  end

  // frame store
  logic [7:0]           mem [StoreWords];
  logic [7:0]           rd_q;
  logic [WordAddrW-1:0] pos_word;
  logic [7:0]           bit_mask, set_word;
  logic                 mem_we;
  logic [WordAddrW-1:0] mem_waddr;
  logic [7:0]           mem_wdata;

  assign pos_word  = WordAddrW'(pos_q >> 3);
  assign bit_mask  = 8'(1) << pos_q[2:0];
  assign set_word  = on_q ? (rd_q | bit_mask) : (rd_q & ~bit_mask);
  assign mem_we    = cmd_i.sweep_wr | cmd_i.set_wr;
  assign mem_waddr = cmd_i.sweep_wr ? cnt_q : pos_word;
  assign mem_wdata = cmd_i.sweep_wr ? ((!cmd_i.sweep_clr && on_q) ? 8'hFF : 8'h00)
                                    : set_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.mem_rd) rd_q <= mem[pos_word];
  end

  // result register
  logic               out_valid_q;
  logic [ColourW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= (in_range && rd_q[pos_q[2:0]]) ? on_col_q : off_col_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.req         = req_q;
  assign sts_o.in_range    = in_range;
  assign sts_o.clear_last  = clear_last;
  assign sts_o.fill_last   = fill_last;
  assign sts_o.frame_empty = frame_pix_q == '0;
  assign sts_o.out_valid   = out_valid_q;

endmodule

### rtl/mono_framebuffer_palette.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_palette
// One-bit-per-pixel frame store with a two-color RGB565 palette.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake            Payload
// s_axis     in   tvalid/tready        tuser: req_type; tdata: x, y, index, r, g, b
// m_axis     out  tvalid/tready        tdata: pixel_565
// cfg        in   cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
// One beat at a time. A set is a read-modify-write of the frame store and a
// read a read of it, each after the pixel index is formed; a fill writes
// ceil(P/8) store words (none for an empty frame) where P is the clamped
// frame size (one store word per cycle).
// After reset a clearing pass writes all 8192 store words with s_axis_tready
// low; config writes are taken during it.
// A read result waits in the output register; the next beat is taken while
// it does, and only a following read stalls until m_axis takes the result.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_palette_macros.svh"

module mono_framebuffer_palette
  import mfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // pixel_x, pixel_y, linear_index,
                                             // colour_red, colour_green, colour_blue
  input  logic [1:0]          s_axis_tuser,  // req_type
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [ColourW-1:0]  m_axis_tdata   // pixel_565
);

  cmd_t cmd;
  sts_t sts;

  mfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign s_axis_tready = cmd.in_ready;

  // no beat taken while the store is being swept
  `MFP_ASSERT(a_no_accept_in_sweep, !(s_axis_tready && cmd.sweep_wr), "accept during sweep")
  // only one writer of the store per cycle
  `MFP_ASSERT(a_one_writer, !(cmd.sweep_wr && cmd.set_wr), "sweep and set write collide")
  // result register never overwritten while full and stalled
  `MFP_ASSERT(a_no_overwrite, !(cmd.load_out && m_axis_tvalid && !m_axis_tready),
              "result overwritten")
  // a taken beat closes the input side next cycle
  `MFP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "input still open after accept")

endmodule
